/* rtl/dmap_tlv_metadata_parser_assert.svh */
// ----------------------------------------------------------------------------
// dmap_tlv_metadata_parser_assert.svh
// Assertion macros used by the parser's queue module.
// ----------------------------------------------------------------------------
`ifndef DMAP_TLV_METADATA_PARSER_ASSERT_SVH
`define DMAP_TLV_METADATA_PARSER_ASSERT_SVH

// Condition must never hold while out of reset.
`define DTLV_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DTLV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dtlv_pkg.sv */
// ----------------------------------------------------------------------------
// dtlv_pkg
// Shared constants, tags and types of the DMAP TLV metadata parser.
// ----------------------------------------------------------------------------
package dtlv_pkg;

  localparam int unsigned MAX_WALK_LEVELS = 5;
  localparam int unsigned LENGTH_BITS     = 32;
  localparam int unsigned LVL_W           = $clog2(MAX_WALK_LEVELS);
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = QPTR_W + 1;
  localparam int unsigned HEADER_BYTES    = 8;
  localparam int unsigned ASTM_LEN        = 4;

  // Four-character tags, big-endian
  localparam logic [31:0] TAG_MINM = 32'h6D696E6D;
  localparam logic [31:0] TAG_ASAR = 32'h61736172;
  localparam logic [31:0] TAG_ASAL = 32'h6173616C;
  localparam logic [31:0] TAG_ASTM = 32'h6173746D;
  localparam logic [31:0] TAG_MLIT = 32'h6D6C6974;
  localparam logic [31:0] TAG_MCON = 32'h6D636F6E;
  localparam logic [31:0] TAG_MLCL = 32'h6D6C636C;

  // String field selectors
  localparam logic [1:0] FIELD_TITLE  = 2'd0;
  localparam logic [1:0] FIELD_ARTIST = 2'd1;
  localparam logic [1:0] FIELD_ALBUM  = 2'd2;

  typedef enum logic [1:0] {
    KIND_STR_START = 2'd0,
    KIND_STR_BYTE  = 2'd1,
    KIND_DURATION  = 2'd2,
    KIND_STATUS    = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    MODE_HEADER = 4'b0001,
    MODE_STRING = 4'b0010,
    MODE_ASTM   = 4'b0100,
    MODE_SKIP   = 4'b1000
  } mode_e;

  // Work handed from the parser to the output side for one byte
  typedef struct packed {
    logic        res_vld;
    kind_e       kind;
    logic [1:0]  sel;
    logic [7:0]  text;
    logic [31:0] dur;
    logic        stat_vld;
    logic        found;
  } job_t;

endpackage

/* rtl/dtlv_front.sv */
// ----------------------------------------------------------------------------
// dtlv_front
// Byte parser: walks nested TLV headers and classifies each byte into a job.
// ----------------------------------------------------------------------------
module dtlv_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                first_byte_i,
  input  logic                                last_byte_i,
  input  logic [dtlv_pkg::LENGTH_BITS-1:0]    body_length_i,
  output logic                                push_o,
  output dtlv_pkg::job_t                      job_o,
  input  logic                                full_i
);

  localparam int unsigned LB = dtlv_pkg::LENGTH_BITS;
  localparam int unsigned LW = dtlv_pkg::LVL_W;
  localparam int unsigned ML = dtlv_pkg::MAX_WALK_LEVELS;

  logic [LB-1:0]      end_q [1:ML-1];
  logic [LB-1:0]      end0_q, end0_n;
  logic [LW-1:0]      lvl_q, lvl_b, lvl_n;
  logic [LB-1:0]      pos_q, pos_b, pos_n;
  logic [63:0]        hdr_q, hdr_b, hdr_n;
  logic [2:0]         hcnt_q, hcnt_b, hcnt_n;
  dtlv_pkg::mode_e    mode_q, mode_b, mode_n;
  logic [LB-1:0]      rem_q, rem_b, rem_n;
  logic [ML-1:0]      skip_q, skip_b, skip_n;
  logic [31:0]        dsh_q, dsh_b, dsh_n;
  logic [31:0]        dur_q, dur_b, dur_n;
  logic [2:0]         fne_q, fne_b, fne_n;
  logic [1:0]         cur_q, cur_b, cur_n;
  logic               end_we;
  logic [LW-1:0]      end_idx;
  logic [LB-1:0]      end_val;
  logic               acc;
  dtlv_pkg::job_t     job;

  assign ready_o = !full_i;
  assign acc     = valid_i && ready_o;
  assign job_o   = job;
  assign push_o  = acc && (job.res_vld || job.stat_vld);

  // Parse one byte
  always_comb begin
    logic [LB-1:0]  p;
    logic           active;
    logic [ML-1:0]  pop;
    logic [LW-1:0]  nl;
    logic [LB-1:0]  cur_end;
    logic [LB-1:0]  gap;
    logic [LB-1:0]  room;
    logic [31:0]    tag;
    logic [LB-1:0]  len;
    logic [1:0]     sel;
    logic           is_str;
    logic           is_cont;
    // restart on a first byte, else continue
    if (first_byte_i) begin
      end0_n = body_length_i;
      lvl_b  = '0;
      pos_b  = '0;
      hdr_b  = '0;
      hcnt_b = '0;
      mode_b = dtlv_pkg::MODE_HEADER;
      rem_b  = '0;
      skip_b = '0;
      dsh_b  = '0;
      dur_b  = '0;
      fne_b  = '0;
      cur_b  = '0;
    end else begin
      end0_n = end0_q;
      lvl_b  = lvl_q;
      pos_b  = pos_q;
      hdr_b  = hdr_q;
      hcnt_b = hcnt_q;
      mode_b = mode_q;
      rem_b  = rem_q;
      skip_b = skip_q;
      dsh_b  = dsh_q;
      dur_b  = dur_q;
      fne_b  = fne_q;
      cur_b  = cur_q;
    end
    lvl_n  = lvl_b;
    pos_n  = pos_b;
    hdr_n  = hdr_b;
    hcnt_n = hcnt_b;
    mode_n = mode_b;
    rem_n  = rem_b;
    skip_n = skip_b;
    dsh_n  = dsh_b;
    dur_n  = dur_b;
    fne_n  = fne_b;
    cur_n  = cur_b;
    end_we  = 1'b0;
    end_idx = '0;
    end_val = '0;
    job     = '0;
    pop     = '0;
    nl      = lvl_b;
    cur_end = end0_n;
    gap     = '0;
    room    = '0;
    tag     = hdr_b[63:32];
    len     = hdr_b[LB-1:0];
    sel     = dtlv_pkg::FIELD_TITLE;
    is_str  = 1'b0;
    is_cont = 1'b0;
    p       = pos_b;
    active  = p < end0_n;

    if (active) begin
      pos_n = p + 1'b1;
      unique case (mode_b)
        dtlv_pkg::MODE_STRING: begin
          rem_n = rem_b - 1'b1;
          if (rem_b == LB'(1)) mode_n = dtlv_pkg::MODE_HEADER;
          job.res_vld = 1'b1;
          job.kind    = dtlv_pkg::KIND_STR_BYTE;
          job.sel     = cur_b;
          job.text    = data_byte_i;
        end
        dtlv_pkg::MODE_ASTM: begin
          dsh_n = {dsh_b[23:0], data_byte_i};
          rem_n = rem_b - 1'b1;
          if (rem_b == LB'(1)) begin
            mode_n      = dtlv_pkg::MODE_HEADER;
            dur_n       = dsh_n;
            job.res_vld = 1'b1;
            job.kind    = dtlv_pkg::KIND_DURATION;
            job.dur     = dsh_n;
          end
        end
        dtlv_pkg::MODE_SKIP: begin
          rem_n = rem_b - 1'b1;
          if (rem_b == LB'(1)) mode_n = dtlv_pkg::MODE_HEADER;
        end
        default: begin
          // close every container that ends here
          for (int d = 1; d < ML; d++) begin
            pop[d] = (LW'(d) <= lvl_b) && (p >= end_q[d]);
          end
          for (int d = ML - 1; d >= 1; d--) begin
            if (nl == LW'(d) && pop[d]) begin
              nl        = LW'(d - 1);
              skip_n[d] = 1'b0;
            end
          end
          lvl_n   = nl;
          cur_end = (nl == '0) ? end0_n : end_q[nl];
          gap     = cur_end - p;
          room    = gap - 1'b1;
          if (skip_n[nl]) begin
            // drop rest of abandoned container
          end else if (hcnt_b == '0 && gap < LB'(dtlv_pkg::HEADER_BYTES)) begin
            skip_n[nl] = 1'b1;
          end else begin
            hdr_n = {hdr_b[55:0], data_byte_i};
            if (hcnt_b == 3'd7) begin
              hcnt_n = '0;
              tag    = hdr_n[63:32];
              len    = hdr_n[LB-1:0];
              hdr_n  = '0;
              is_str = 1'b1;
              priority if (tag == dtlv_pkg::TAG_MINM) sel = dtlv_pkg::FIELD_TITLE;
              else if (tag == dtlv_pkg::TAG_ASAR) sel = dtlv_pkg::FIELD_ARTIST;
              else if (tag == dtlv_pkg::TAG_ASAL) sel = dtlv_pkg::FIELD_ALBUM;
              else is_str = 1'b0;
              is_cont = (tag == dtlv_pkg::TAG_MLIT) || (tag == dtlv_pkg::TAG_MCON) ||
                        (tag == dtlv_pkg::TAG_MLCL);
              if (len > room) begin
                skip_n[nl] = 1'b1;
              end else if (is_str) begin
                fne_n[sel] = (len != '0);
                cur_n      = sel;
                if (len != '0) begin
                  mode_n = dtlv_pkg::MODE_STRING;
                  rem_n  = len;
                end
                job.res_vld = 1'b1;
                job.kind    = dtlv_pkg::KIND_STR_START;
                job.sel     = sel;
              end else if (len == '0) begin
                // empty leaf: nothing to do
              end else if (tag == dtlv_pkg::TAG_ASTM && len == LB'(dtlv_pkg::ASTM_LEN)) begin
                mode_n = dtlv_pkg::MODE_ASTM;
                rem_n  = len;
                dsh_n  = '0;
              end else if (is_cont && nl < LW'(ML - 1)) begin
                lvl_n           = nl + 1'b1;
                end_we          = 1'b1;
                end_idx         = nl + 1'b1;
                end_val         = p + 1'b1 + len;
                skip_n[lvl_n]   = 1'b0;
              end else begin
                mode_n = dtlv_pkg::MODE_SKIP;
                rem_n  = len;
              end
            end else begin
              hcnt_n = hcnt_b + 1'b1;
            end
          end
        end
      endcase
    end

    // final status after this byte's result
    job.stat_vld = last_byte_i;
    job.found    = last_byte_i && (end0_n >= LB'(dtlv_pkg::HEADER_BYTES)) &&
                   ((|fne_n) || (dur_n != '0));
  end

  // Container end offsets
  always_ff @(posedge clk_i) begin
    if (acc && end_we) end_q[end_idx] <= end_val;
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end0_q <= '0;
      lvl_q  <= '0;
      pos_q  <= '0;
      hdr_q  <= '0;
      hcnt_q <= '0;
      mode_q <= dtlv_pkg::MODE_HEADER;
      rem_q  <= '0;
      skip_q <= '0;
      dsh_q  <= '0;
      dur_q  <= '0;
      fne_q  <= '0;
      cur_q  <= '0;
    end else if (acc) begin
      end0_q <= end0_n;
      lvl_q  <= lvl_n;
      pos_q  <= pos_n;
      hdr_q  <= hdr_n;
      hcnt_q <= hcnt_n;
      mode_q <= mode_n;
      rem_q  <= rem_n;
      skip_q <= skip_n;
      dsh_q  <= dsh_n;
      dur_q  <= dur_n;
      fne_q  <= fne_n;
      cur_q  <= cur_n;
    end
  end

endmodule

/* rtl/dtlv_fifo.sv */
// ----------------------------------------------------------------------------
// dtlv_fifo
// Short job queue between the parser and the output serializer.
// ----------------------------------------------------------------------------
`include "dmap_tlv_metadata_parser_assert.svh"

module dtlv_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dtlv_pkg::job_t  job_i,
  output logic            full_o,
  input  logic            pop_i,
  output dtlv_pkg::job_t  job_o,
  output logic            empty_o
);

  dtlv_pkg::job_t                   mem_q [dtlv_pkg::QUEUE_DEPTH];
  logic [dtlv_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [dtlv_pkg::QCNT_W-1:0]      cnt_q;
  logic                             do_push, do_pop;

  function automatic logic [dtlv_pkg::QCNT_W-1:0] QCNT_ONE(input logic b);
    QCNT_ONE = {{(dtlv_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full_o  = (cnt_q == dtlv_pkg::QCNT_W'(dtlv_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_q];

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= job_i;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + 1'b1;
      if (do_pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCNT_ONE(do_push) - QCNT_ONE(do_pop);
    end
  end

  `DTLV_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `DTLV_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")
  `DTLV_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > dtlv_pkg::QCNT_W'(dtlv_pkg::QUEUE_DEPTH), "count beyond depth")
  `DTLV_ASSERT_NEXT(a_ptr_gap, clk_i, rst_ni, 1'b1, (wr_q - rd_q) == cnt_q[dtlv_pkg::QPTR_W-1:0], "pointers disagree with count")

endmodule

/* rtl/dtlv_back.sv */
// ----------------------------------------------------------------------------
// dtlv_back
// Output serializer: turns each queued job into one or two result beats.
// ----------------------------------------------------------------------------
module dtlv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  dtlv_pkg::job_t  job_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output dtlv_pkg::kind_e kind_o,
  output logic [1:0]      sel_o,
  output logic [7:0]      text_o,
  output logic [31:0]     dur_o,
  output logic            found_o,
  output logic            last_o
);

  logic            vld_q, vld_d;
  logic            done_q, done_d;
  dtlv_pkg::kind_e kind_q, kind_d;
  logic [1:0]      sel_q, sel_d;
  logic [7:0]      text_q, text_d;
  logic [31:0]     dur_q, dur_d;
  logic            found_q, found_d;
  logic            last_q, last_d;
  logic            free;

  assign free = !vld_q || ready_i;

  // Pick the next beat from the head job
  always_comb begin
    pop_o   = 1'b0;
    vld_d   = vld_q;
    done_d  = done_q;
    kind_d  = kind_q;
    sel_d   = sel_q;
    text_d  = text_q;
    dur_d   = dur_q;
    found_d = found_q;
    last_d  = last_q;
    if (free) begin
      vld_d = !empty_i;
      if (!empty_i) begin
        if (job_i.res_vld && !done_q) begin
          kind_d  = job_i.kind;
          sel_d   = job_i.sel;
          text_d  = job_i.text;
          dur_d   = job_i.dur;
          found_d = 1'b0;
          last_d  = !job_i.stat_vld;
          pop_o   = !job_i.stat_vld;
          done_d  = job_i.stat_vld;
        end else begin
          kind_d  = dtlv_pkg::KIND_STATUS;
          sel_d   = '0;
          text_d  = '0;
          dur_d   = '0;
          found_d = job_i.found;
          last_d  = 1'b1;
          pop_o   = 1'b1;
          done_d  = 1'b0;
        end
      end
    end
  end

  // Hold the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    sel_q   <= sel_d;
    text_q  <= text_d;
    dur_q   <= dur_d;
    found_q <= found_d;
    last_q  <= last_d;
  end

  assign valid_o = vld_q;
  assign kind_o  = kind_q;
  assign sel_o   = sel_q;
  assign text_o  = text_q;
  assign dur_o   = dur_q;
  assign found_o = found_q;
  assign last_o  = last_q;

endmodule

/* rtl/dmap_tlv_metadata_parser.sv */
// ----------------------------------------------------------------------------
// dmap_tlv_metadata_parser
// Streams DMAP message bytes and emits title, artist, album, duration, status.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one message byte per beat; tuser marks the first
//   byte (body length is sampled from tdata then), tlast the final byte.
//   Master channel gives result beats: string start, string byte, duration
//   and, after the final byte, a status beat with the found flag. tlast
//   marks the last result beat caused by one input byte.
//   Throughput: one input byte per cycle while the job queue has room; the
//   parser updates its container stack and header counters as each byte
//   is accepted. A byte that causes two results (a payload result plus
//   status) gives two output beats. Each result's job enters the
//   four-entry queue when its byte is accepted, and the output register
//   loads it from the queue head when the register is free.
//   Reset clears parse state, the queue and the output valid flag; a message
//   must begin with a first-byte beat.
//   When the receiver stalls, results pile up in the job queue; once it is
//   full the slave channel's tready drops until space frees up.
// ----------------------------------------------------------------------------
module dmap_tlv_metadata_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // [7:0] data_byte, [39:8] body_length
  input  logic        s_axis_tuser_i,  // [0] first_byte
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // [7:0] text_byte, [39:8] duration_value,
                                       // [40] found_any, [47:41] zero
  output logic [3:0]  m_axis_tuser_o,  // [1:0] result_kind, [3:2] field_select
  output logic        m_axis_tlast_o
);

  logic            push, full, pop, empty;
  dtlv_pkg::job_t  job_in, job_head;
  dtlv_pkg::kind_e kind;
  logic [1:0]      sel;
  logic [7:0]      text;
  logic [31:0]     dur;
  logic            found;

  dtlv_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .data_byte_i   (s_axis_tdata_i[7:0]),
    .first_byte_i  (s_axis_tuser_i),
    .last_byte_i   (s_axis_tlast_i),
    .body_length_i (s_axis_tdata_i[39:8]),
    .push_o        (push),
    .job_o         (job_in),
    .full_i        (full)
  );

  dtlv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_head),
    .empty_o (empty)
  );

  dtlv_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_head),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .kind_o  (kind),
    .sel_o   (sel),
    .text_o  (text),
    .dur_o   (dur),
    .found_o (found),
    .last_o  (m_axis_tlast_o)
  );

  // Pack result beat
  assign m_axis_tdata_o = {7'b0, found, dur, text};
  assign m_axis_tuser_o = {sel, kind};

endmodule
